// ===== rtl/hfa_pkg.sv =====
// ----------------------------------------------------------------------------
// hfa_pkg
// Types and codes shared by the hole fit allocator modules.
// ----------------------------------------------------------------------------
package hfa_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // fit mode codes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [20:0] SUM_MAX = 21'h1FFFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] item_size;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        granted;
        logic [4:0]  hole_index;
        logic [15:0] hole_length;
        logic [15:0] leftover;
        logic [20:0] internal_sum;
        logic [20:0] external_sum;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic finish;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic new_scan;
        logic scan_last;
    } t_dp_stat;

    function automatic logic [20:0] clip_sum(input logic [63:0] v);
        return (v > 64'(SUM_MAX)) ? SUM_MAX : v[20:0];
    endfunction

endpackage

// ===== rtl/hfa_ram.sv =====
// ----------------------------------------------------------------------------
// hfa_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// hfa_ctrl
// Sequencer: accepts a transaction, runs the hole scan for allocates on a
// non-empty table, then commits the update and the result.
// ----------------------------------------------------------------------------
module hfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hfa_pkg::t_dp_stat i_stat,
    output hfa_pkg::t_ctl_cmd o_cmd,
    output logic              o_busy
);

    hfa_pkg::t_state r_state;
    hfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            hfa_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.new_scan ? hfa_pkg::S_SCAN : hfa_pkg::S_FINISH;
                end
            end
            hfa_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = hfa_pkg::S_DRAIN;
                end
            end
            // last read word is compared here
            hfa_pkg::S_DRAIN: begin
                n_state = hfa_pkg::S_FINISH;
            end
            hfa_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = hfa_pkg::S_IDLE;
            end
            default: begin
                n_state = hfa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/hfa_dp.sv =====
// ----------------------------------------------------------------------------
// hfa_dp
// Datapath: hole size RAM, used marks, scan compare, totals and the result
// register.
// ----------------------------------------------------------------------------
module hfa_dp #(
    parameter int HOLES     = 32,
    parameter int SIZE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hfa_pkg::t_item    i_item,
    input  logic [1:0]        i_fit_mode,
    input  hfa_pkg::t_ctl_cmd i_cmd,
    output hfa_pkg::t_dp_stat o_stat,
    output logic              o_done,
    output hfa_pkg::t_result  o_result
);

    localparam int IDX_W = $clog2(HOLES);
    localparam int CNT_W = $clog2(HOLES + 1);
    localparam int TOT_W = SIZE_BITS + IDX_W;

    logic [1:0]           r_cmd;
    logic [SIZE_BITS-1:0] r_size;
    logic [IDX_W-1:0]     r_cnt;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick_idx;
    logic [SIZE_BITS-1:0] r_pick_size;
    logic                 r_used [HOLES];
    logic [CNT_W-1:0]     r_loaded;
    logic [TOT_W-1:0]     r_int_tot;
    logic [TOT_W-1:0]     r_ext_tot;
    logic [TOT_W-1:0]     r_load_tot;
    hfa_pkg::t_result     r_res;
    logic                 r_res_vld;

    logic [SIZE_BITS-1:0] rd_size;
    logic                 fits;
    logic                 take;
    logic                 full;
    logic                 ram_we;

    logic [1:0]           n_status;
    logic                 n_granted;
    logic [IDX_W-1:0]     n_idx;
    logic [SIZE_BITS-1:0] n_len;
    logic [SIZE_BITS-1:0] n_left;
    logic [TOT_W-1:0]     n_int_tot;
    logic [TOT_W-1:0]     n_ext_tot;
    logic [TOT_W-1:0]     n_load_tot;
    logic [CNT_W-1:0]     n_loaded;
    logic                 n_set_used;
    logic                 n_clr_slot;
    logic                 n_clr_all;

    assign full = (32'(r_loaded) >= HOLES);

    assign o_stat.new_scan  = (i_item.command == hfa_pkg::CMD_ALLOC) && (r_loaded != '0);
    assign o_stat.scan_last = ((32'(r_cnt) + 32'd1) == 32'(r_loaded));

    assign ram_we = i_cmd.finish && (r_cmd == hfa_pkg::CMD_LOAD) && !full;

    hfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (HOLES)
    ) u_sizes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_loaded[IDX_W-1:0]),
        .i_wdata (r_size),
        .i_raddr (r_cnt),
        .o_rdata (rd_size)
    );

    // candidate selection, one hole per cycle
    always_comb begin
        fits = r_cmp_vld && !r_used[r_cmp_idx] && (rd_size >= r_size);
        take = 1'b0;
        if (fits) begin
            priority if (!r_found) begin
                take = 1'b1;
            end else if (i_fit_mode == hfa_pkg::FIT_BEST) begin
                take = (rd_size < r_pick_size);
            end else if (i_fit_mode == hfa_pkg::FIT_WORST) begin
                take = (rd_size >= r_pick_size);
            end else begin
                take = 1'b0;
            end
        end
    end

    // commit values
    always_comb begin
        n_status   = hfa_pkg::ST_DONE;
        n_granted  = 1'b0;
        n_idx      = '0;
        n_len      = '0;
        n_left     = '0;
        n_int_tot  = r_int_tot;
        n_ext_tot  = r_ext_tot;
        n_load_tot = r_load_tot;
        n_loaded   = r_loaded;
        n_set_used = 1'b0;
        n_clr_slot = 1'b0;
        n_clr_all  = 1'b0;
        unique case (r_cmd)
            hfa_pkg::CMD_LOAD: begin
                if (full) begin
                    n_status = hfa_pkg::ST_FULL;
                end else begin
                    n_idx      = r_loaded[IDX_W-1:0];
                    n_ext_tot  = r_ext_tot + TOT_W'(r_size);
                    n_load_tot = r_load_tot + TOT_W'(r_size);
                    n_loaded   = r_loaded + CNT_W'(1);
                    n_clr_slot = 1'b1;
                end
            end
            hfa_pkg::CMD_ALLOC: begin
                if (r_found) begin
                    n_granted  = 1'b1;
                    n_idx      = r_pick_idx;
                    n_len      = r_pick_size;
                    n_left     = r_pick_size - r_size;
                    n_int_tot  = r_int_tot + TOT_W'(n_left);
                    n_ext_tot  = r_ext_tot - TOT_W'(r_pick_size);
                    n_set_used = 1'b1;
                end else begin
                    n_status = hfa_pkg::ST_NO_FIT;
                end
            end
            hfa_pkg::CMD_RELEASE: begin
                n_int_tot = '0;
                n_ext_tot = r_load_tot;
                n_clr_all = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HOLES; k++) begin
                r_used[k] <= 1'b0;
            end
            r_loaded   <= '0;
            r_int_tot  <= '0;
            r_ext_tot  <= '0;
            r_load_tot <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            r_res_vld <= i_cmd.finish;
            if (i_cmd.accept) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_loaded   <= n_loaded;
                r_int_tot  <= n_int_tot;
                r_ext_tot  <= n_ext_tot;
                r_load_tot <= n_load_tot;
                if (n_clr_all) begin
                    for (int k = 0; k < HOLES; k++) begin
                        r_used[k] <= 1'b0;
                    end
                end else if (n_clr_slot) begin
                    r_used[n_idx] <= 1'b0;
                end else if (n_set_used) begin
                    r_used[n_idx] <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_item.command;
            r_size <= SIZE_BITS'(i_item.item_size);
            r_cnt  <= '0;
        end else if (i_cmd.scan) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_cnt;
        end
        if (take) begin
            r_pick_idx  <= r_cmp_idx;
            r_pick_size <= rd_size;
        end
        if (i_cmd.finish) begin
            r_res.status       <= n_status;
            r_res.granted      <= n_granted;
            r_res.hole_index   <= 5'(32'(n_idx));
            r_res.hole_length  <= 16'(32'(n_len));
            r_res.leftover     <= 16'(32'(n_left));
            r_res.internal_sum <= hfa_pkg::clip_sum(64'(n_int_tot));
            r_res.external_sum <= hfa_pkg::clip_sum(64'(n_ext_tot));
        end
    end

    assign o_done   = r_res_vld;
    assign o_result = r_res;

endmodule

// ===== rtl/hole_fit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// hole_fit_allocator_top
// Hole table allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// A transaction is taken when i_start is high and o_busy is low; its result
// appears on o_result for one cycle with o_done high and cannot be held off.
// Load, release and unused commands go from accept straight to the commit
// state, and so does an allocate on an empty table. Otherwise an allocate
// scans the loaded holes: the hole sizes sit in a RAM with a single
// registered read port, so the scan reads one hole per cycle; then the drain
// state compares the last word and the finish state commits the update.
// fit_mode is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module hole_fit_allocator_top #(
    parameter int HOLES     = 32,
    parameter int SIZE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  hfa_pkg::t_item   i_item,
    output logic             o_busy,
    output logic             o_done,
    output hfa_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_wdata
);

    logic [1:0]        r_fit_mode;
    hfa_pkg::t_ctl_cmd ctl_cmd;
    hfa_pkg::t_dp_stat dp_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= hfa_pkg::FIT_FIRST;
        end else if (i_cfg_we) begin
            r_fit_mode <= i_cfg_wdata;
        end
    end

    hfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (dp_stat),
        .o_cmd   (ctl_cmd),
        .o_busy  (o_busy)
    );

    hfa_dp #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_fit_mode (r_fit_mode),
        .i_cmd      (ctl_cmd),
        .o_stat     (dp_stat),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // an accepted transaction keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accept");

    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // a grant always reports done status
    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.granted) |-> (o_result.status == hfa_pkg::ST_DONE))
        else $error("grant with failure status");

    // no grant means no hole length and no leftover
    a_nogrant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.granted)
            |-> (o_result.hole_length == '0 && o_result.leftover == '0))
        else $error("length or leftover without grant");

endmodule
